@@ sv/olid_pkg.sv @@
`timescale 1ns / 1ps

package olid_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_CHANGE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_NOP  = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_CHG  = 3'd3,
    CELL_SRCH = 3'd4
  } cell_op_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_req_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] found_position;
    logic [5:0] entry_count;
  } out_rsp_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] value;
    logic [5:0]  position;
  } cell_ctrl_t;

endpackage

@@ sv/olid_cell.sv @@
`timescale 1ns / 1ps

module olid_cell import olid_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] count,
  input  logic [31:0]   left_entry,
  input  logic [31:0]   right_entry,
  output logic [31:0]   entry_out,
  output logic          match_out
);

  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;
  localparam logic [CMPW-1:0] POS_I = CMPW'(IDX + 1);

  logic [31:0]     entry_r;
  logic [31:0]     entry_nxt;
  logic            match_r;
  logic            match_nxt;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;

  assign pos_w = CMPW'(ctrl.position);
  assign cnt_w = CMPW'(count);

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    case (ctrl.op)
      CELL_INS: begin
        if (pos_w == POS_I) begin
          entry_nxt = ctrl.value;
        end else if (pos_w < POS_I) begin
          entry_nxt = left_entry;
        end
      end
      CELL_DEL: begin
        if (pos_w <= POS_I) begin
          entry_nxt = right_entry;
        end
      end
      CELL_CHG: begin
        if (pos_w == POS_I) begin
          entry_nxt = ctrl.value;
        end
      end
      CELL_SRCH: begin
        match_nxt = (entry_r == ctrl.value) && (POS_I <= cnt_w);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry_out = entry_r;
  assign match_out = match_r;

endmodule

@@ sv/ordered_list_insert_delete_search_core.sv @@
`timescale 1ns / 1ps
// Each result goes to res_r, then to the output register; one request is held at a time.
// Search: all cells compare at once, then the registered match bits
// are scanned eight per cycle until the first hit or the last group.
// A new request is taken as soon as the previous result sits in the output register, so
// a stalled output (out_valid high, out_ready low) holds off new requests.
// Synchronous active-low reset empties the list; entry storage is not cleared.
module ordered_list_insert_delete_search_core import olid_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;
  localparam int NGRP = (DEPTH + 7) / 8;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [GW-1:0]   grp_r, grp_nxt;
  out_rsp_t        res_r, res_nxt;
  out_rsp_t        out_rsp_r, out_rsp_nxt;
  logic            out_valid_r, out_valid_nxt;

  cell_ctrl_t      ctrl;
  logic [31:0]     entry_vec [DEPTH];
  logic [DEPTH-1:0] match_vec;
  logic [NGRP*8-1:0] match_pad;
  logic [7:0]      grp_bits;
  logic [2:0]      hit_k;
  logic [GW+3:0]   hit_sum;
  logic            accept;
  logic            load_out;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [31:0] left_e;
      logic [31:0] right_e;
      if (gi == 0) begin : g_first
        assign left_e = '0;
      end else begin : g_mid_l
        assign left_e = entry_vec[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_mid_r
        assign right_e = entry_vec[gi+1];
      end
      olid_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .count       (count_r),
        .left_entry  (left_e),
        .right_entry (right_e),
        .entry_out   (entry_vec[gi]),
        .match_out   (match_vec[gi])
      );
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign pos_w     = CMPW'(in_req.position);
  assign cnt_w     = CMPW'(count_r);
  assign match_pad = (NGRP * 8)'(match_vec);
  assign grp_bits  = match_pad[{grp_r, 3'b000} +: 8];

  always_comb begin
    hit_k = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (grp_bits[k]) begin
        hit_k = 3'(k);
      end
    end
  end

  assign hit_sum = (GW + 4)'({grp_r, hit_k}) + (GW + 4)'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    grp_nxt       = grp_r;
    res_nxt       = res_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r;
    ctrl.op       = CELL_NOP;
    ctrl.value    = in_req.value;
    ctrl.position = in_req.position;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.status         = ST_OK;
          res_nxt.found_position = 6'd0;
          state_nxt              = S_DONE;
          case (in_req.mode)
            MODE_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                res_nxt.status = ST_BAD_POS;
              end else begin
                ctrl.op   = CELL_INS;
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_DELETE: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                res_nxt.status = ST_BAD_POS;
              end else begin
                ctrl.op   = CELL_DEL;
                count_nxt = count_r - CW'(1);
              end
            end
            MODE_SEARCH: begin
              ctrl.op   = CELL_SRCH;
              grp_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                res_nxt.status = ST_BAD_POS;
              end else begin
                ctrl.op = CELL_CHG;
              end
            end
          endcase
          res_nxt.entry_count = 6'(count_nxt);
        end
      end
      S_SCAN: begin
        if (|grp_bits) begin
          res_nxt.status         = ST_OK;
          res_nxt.found_position = 6'(hit_sum);
          state_nxt              = S_DONE;
        end else if (grp_r == GW'(NGRP - 1)) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          grp_nxt = grp_r + GW'(1);
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_rsp_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      grp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
